// ----- rtl/swmh_pkg.sv -----
package swmh_pkg;

  localparam int HASH_COUNT_DEF = 8;
  localparam int NUM_LABELS_DEF = 256;
  localparam int MULT_MAX_DEF   = 8;
  localparam int WINDOW_MAX_DEF = 1024;

  localparam int VAL_W     = 23;
  localparam int LBL_W     = 8;
  localparam int HASH_W    = 3;
  localparam int RANK_W    = 4;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int BATCH_W   = 10;

  localparam logic [VAL_W-1:0] EMPTY_VALUE = 23'd5000000;
  localparam int               BATCH_MAX   = 1024;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN  = 2'd0,
    REG_BATCH_LEN   = 2'd1,
    REG_MULT_LIMIT  = 2'd2,
    REG_LABEL_COUNT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              command;
    logic [HASH_W-1:0] hash_index;
    logic [LBL_W-1:0]  table_label;
    logic [RANK_W-1:0] rank;
    logic [VAL_W-1:0]  alloc_value;
    logic [LBL_W-1:0]  stream_label;
  } in_item_t;

  typedef struct packed {
    logic [HASH_W-1:0] out_hash;
    logic [VAL_W-1:0]  min_value;
    logic [LBL_W-1:0]  min_label;
    logic              window_empty;
    logic              count_saturated;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_LOAD_RD, ST_LOAD_WR, ST_DROP_CHK, ST_DROP_RD, ST_DROP_CNT,
    ST_DROP_WR, ST_PUSH_RD, ST_PUSH_WR, ST_SCAN_INIT, ST_SCAN, ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD_RD, OP_LOAD_WR, OP_DROP_RD, OP_DROP_CNT, OP_DROP_WR,
    OP_PUSH_RD, OP_PUSH_WR, OP_SCAN_INIT, OP_SCAN, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic load_ok;
    logic push_ok;
    logic need_drop;
    logic report_due;
    logic scan_done;
    logic out_free;
    logic hash_last;
  } dp_status_t;

endpackage

// ----- rtl/sliding_window_multiset_minhash.sv -----
// Sliding-window multiset MinHash. Loads (command 0) write a prefix-minimum allocation
// value; ranks of one hash and label must be loaded in increasing order. Pushes (command 1)
// enter a label into the window, retiring the oldest labels first, and every batch_len
// pushes produce one report of HASH_COUNT items, hash 0 first, last set on the final one.
// A load reads the entry of the previous rank and then writes; a push first retires labels
// while the window is full, then updates the label count and the ring; an ignored load or
// push goes back to idle after decode. In a report, each hash scans every label through the
// single read port of the label-count memory, one label per cycle. Input is taken one item
// at a time; a finished result waits in the output register while the next hash is scanned.
module sliding_window_multiset_minhash #(
  parameter int HASH_COUNT = swmh_pkg::HASH_COUNT_DEF,
  parameter int NUM_LABELS = swmh_pkg::NUM_LABELS_DEF,
  parameter int MULT_MAX   = swmh_pkg::MULT_MAX_DEF,
  parameter int WINDOW_MAX = swmh_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swmh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swmh_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  swmh_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output swmh_pkg::out_item_t            out_data_o
);

  swmh_pkg::dp_op_e     op;
  swmh_pkg::dp_status_t status;

  swmh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .status_i(status), .op_o(op), .in_stall_o
  );

  swmh_dp #(
    .HASH_COUNT(HASH_COUNT), .NUM_LABELS(NUM_LABELS),
    .MULT_MAX(MULT_MAX), .WINDOW_MAX(WINDOW_MAX)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_data_i, .out_stall_i,
    .op_i(op), .status_o(status), .out_valid_o, .out_data_o
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  a_last_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.out_hash == swmh_pkg::HASH_W'(HASH_COUNT - 1))
    else $error("last flag on wrong hash");

  a_report_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input open during a report");

endmodule

// ----- rtl/swmh_ram.sv -----
module swmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/swmh_ctrl.sv -----
module swmh_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  swmh_pkg::dp_status_t status_i,
  output swmh_pkg::dp_op_e     op_o,
  output logic                 in_stall_o
);

  swmh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swmh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = swmh_pkg::OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      swmh_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_o    = swmh_pkg::OP_CAPTURE;
          state_d = swmh_pkg::ST_DECODE;
        end
      end
      swmh_pkg::ST_DECODE: begin
        priority if (status_i.load_ok) state_d = swmh_pkg::ST_LOAD_RD;
        else if (status_i.push_ok) state_d = swmh_pkg::ST_DROP_CHK;
        else state_d = swmh_pkg::ST_IDLE;
      end
      swmh_pkg::ST_LOAD_RD: begin
        op_o    = swmh_pkg::OP_LOAD_RD;
        state_d = swmh_pkg::ST_LOAD_WR;
      end
      swmh_pkg::ST_LOAD_WR: begin
        op_o    = swmh_pkg::OP_LOAD_WR;
        state_d = swmh_pkg::ST_IDLE;
      end
      swmh_pkg::ST_DROP_CHK: begin
        state_d = status_i.need_drop ? swmh_pkg::ST_DROP_RD : swmh_pkg::ST_PUSH_RD;
      end
      swmh_pkg::ST_DROP_RD: begin
        op_o    = swmh_pkg::OP_DROP_RD;
        state_d = swmh_pkg::ST_DROP_CNT;
      end
      swmh_pkg::ST_DROP_CNT: begin
        op_o    = swmh_pkg::OP_DROP_CNT;
        state_d = swmh_pkg::ST_DROP_WR;
      end
      swmh_pkg::ST_DROP_WR: begin
        op_o    = swmh_pkg::OP_DROP_WR;
        state_d = swmh_pkg::ST_DROP_CHK;
      end
      swmh_pkg::ST_PUSH_RD: begin
        op_o    = swmh_pkg::OP_PUSH_RD;
        state_d = swmh_pkg::ST_PUSH_WR;
      end
      swmh_pkg::ST_PUSH_WR: begin
        op_o    = swmh_pkg::OP_PUSH_WR;
        state_d = status_i.report_due ? swmh_pkg::ST_SCAN_INIT : swmh_pkg::ST_IDLE;
      end
      swmh_pkg::ST_SCAN_INIT: begin
        op_o    = swmh_pkg::OP_SCAN_INIT;
        state_d = swmh_pkg::ST_SCAN;
      end
      swmh_pkg::ST_SCAN: begin
        op_o = swmh_pkg::OP_SCAN;
        if (status_i.scan_done) state_d = swmh_pkg::ST_EMIT;
      end
      swmh_pkg::ST_EMIT: begin
        op_o = swmh_pkg::OP_EMIT;
        if (status_i.out_free) begin
          state_d = status_i.hash_last ? swmh_pkg::ST_IDLE : swmh_pkg::ST_SCAN_INIT;
        end
      end
      default: state_d = swmh_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/swmh_dp.sv -----
module swmh_dp #(
  parameter int HASH_COUNT = swmh_pkg::HASH_COUNT_DEF,
  parameter int NUM_LABELS = swmh_pkg::NUM_LABELS_DEF,
  parameter int MULT_MAX   = swmh_pkg::MULT_MAX_DEF,
  parameter int WINDOW_MAX = swmh_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swmh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [swmh_pkg::CFG_W-1:0]          cfg_data_i,
  input  swmh_pkg::in_item_t                  in_data_i,
  input  logic                                out_stall_i,
  input  swmh_pkg::dp_op_e                    op_i,
  output swmh_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  output swmh_pkg::out_item_t                 out_data_o
);

  localparam int TDEPTH = HASH_COUNT * NUM_LABELS * MULT_MAX;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int CAW    = $clog2(NUM_LABELS);
  localparam int WPW    = $clog2(WINDOW_MAX);
  localparam int PW     = WPW + 1;
  localparam int FW     = $clog2(WINDOW_MAX + 1);
  localparam int MLW    = $clog2(MULT_MAX + 1);
  localparam int LCW    = $clog2(NUM_LABELS + 1);
  localparam int HW     = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
  localparam int VW     = swmh_pkg::VAL_W;

  function automatic logic [TAW-1:0] taddr(input int h, input int l, input int r);
    return TAW'((h * NUM_LABELS + l) * MULT_MAX + r - 1);
  endfunction

  // configuration
  logic [swmh_pkg::CFG_W-1:0] win_len_q, bat_len_q;
  logic [3:0]                 mult_lim_q;
  logic [8:0]                 lbl_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q  <= 11'd100;
      bat_len_q  <= 11'd1;
      mult_lim_q <= 4'd8;
      lbl_cnt_q  <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (swmh_pkg::cfg_reg_e'(cfg_idx_i))
        swmh_pkg::REG_WINDOW_LEN:  win_len_q  <= cfg_data_i;
        swmh_pkg::REG_BATCH_LEN:   bat_len_q  <= cfg_data_i;
        swmh_pkg::REG_MULT_LIMIT:  mult_lim_q <= cfg_data_i[3:0];
        swmh_pkg::REG_LABEL_COUNT: lbl_cnt_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic [FW-1:0]              wl;
  logic [swmh_pkg::CFG_W-1:0] bl;
  logic [MLW-1:0]             ml;
  logic [LCW-1:0]             lc;

  always_comb begin
    if (win_len_q == '0) wl = FW'(1);
    else if (int'(win_len_q) > WINDOW_MAX) wl = FW'(WINDOW_MAX);
    else wl = FW'(win_len_q);
    if (bat_len_q == '0) bl = 11'd1;
    else if (int'(bat_len_q) > swmh_pkg::BATCH_MAX) bl = 11'(swmh_pkg::BATCH_MAX);
    else bl = bat_len_q;
    if (mult_lim_q == '0) ml = MLW'(1);
    else if (int'(mult_lim_q) > MULT_MAX) ml = MLW'(MULT_MAX);
    else ml = MLW'(mult_lim_q);
    if (lbl_cnt_q == '0) lc = LCW'(1);
    else if (int'(lbl_cnt_q) > NUM_LABELS) lc = LCW'(NUM_LABELS);
    else lc = LCW'(lbl_cnt_q);
  end

  // state
  swmh_pkg::in_item_t           item_q;
  logic [WPW-1:0]               wp_q;
  logic [FW-1:0]                fill_q;
  logic [swmh_pkg::BATCH_W-1:0] batch_q;
  logic                         sat_q;
  logic [HW-1:0]                hash_q;
  logic [CAW-1:0]               iss_lab_q, s1_lab_q, s2_lab_q, best_lab_q;
  logic                         iss_on_q, s1_v_q, s2_v_q, s2_pres_q, found_q;
  logic [VW-1:0]                best_q;
  logic [NUM_LABELS-1:0]        vld_q;
  logic                         vrd_q;
  logic                         out_v_q;
  swmh_pkg::out_item_t          out_q;

  // memories
  logic           t_we, t_re, c_we, c_re, r_we, r_re;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [VW-1:0]  t_wdata, t_rdata;
  logic [CAW-1:0] c_waddr, c_raddr;
  logic [FW-1:0]  c_wdata, c_rdata;
  logic [WPW-1:0] r_raddr;
  logic [swmh_pkg::LBL_W-1:0] r_rdata;

  swmh_ram #(.WIDTH(VW), .DEPTH(TDEPTH)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  swmh_ram #(.WIDTH(FW), .DEPTH(NUM_LABELS)) u_counts (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .re_i(c_re), .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  swmh_ram #(.WIDTH(swmh_pkg::LBL_W), .DEPTH(WINDOW_MAX)) u_ring (
    .clk_i, .we_i(r_we), .waddr_i(wp_q), .wdata_i(item_q.stream_label),
    .re_i(r_re), .raddr_i(r_raddr), .rdata_o(r_rdata)
  );

  // derived values
  logic [FW-1:0]  cnt_rd, cnt_clip;
  logic [PW-1:0]  old_tmp;
  logic [VW-1:0]  load_prev, load_val;
  logic           out_free, hash_last;

  assign cnt_rd    = vrd_q ? c_rdata : '0;
  assign cnt_clip  = (int'(cnt_rd) > int'(ml)) ? FW'(ml) : cnt_rd;
  assign old_tmp   = PW'(wp_q) + PW'(WINDOW_MAX) - PW'(fill_q);
  assign r_raddr   = (int'(old_tmp) >= WINDOW_MAX) ? WPW'(old_tmp - PW'(WINDOW_MAX))
                                                   : WPW'(old_tmp);
  assign load_prev = (item_q.rank == 4'd1) ? swmh_pkg::EMPTY_VALUE : t_rdata;
  assign load_val  = (item_q.alloc_value < load_prev) ? item_q.alloc_value : load_prev;
  assign out_free  = !out_v_q || !out_stall_i;
  assign hash_last = int'(hash_q) == HASH_COUNT - 1;

  always_comb begin
    t_we    = 1'b0;
    t_re    = 1'b0;
    t_waddr = taddr(int'(item_q.hash_index), int'(item_q.table_label), int'(item_q.rank));
    t_raddr = taddr(int'(item_q.hash_index), int'(item_q.table_label),
                    int'(item_q.rank) - 1);
    t_wdata = load_val;
    c_we    = 1'b0;
    c_re    = 1'b0;
    c_waddr = CAW'(item_q.stream_label);
    c_raddr = CAW'(item_q.stream_label);
    c_wdata = cnt_rd + FW'(1);
    r_we    = 1'b0;
    r_re    = 1'b0;
    unique case (op_i)
      swmh_pkg::OP_LOAD_RD: t_re = 1'b1;
      swmh_pkg::OP_LOAD_WR: t_we = 1'b1;
      swmh_pkg::OP_DROP_RD: r_re = 1'b1;
      swmh_pkg::OP_DROP_CNT: begin
        c_re    = 1'b1;
        c_raddr = CAW'(r_rdata);
      end
      swmh_pkg::OP_DROP_WR: begin
        c_we    = cnt_rd != '0;
        c_waddr = CAW'(r_rdata);
        c_wdata = cnt_rd - FW'(1);
      end
      swmh_pkg::OP_PUSH_RD: c_re = 1'b1;
      swmh_pkg::OP_PUSH_WR: begin
        c_we = 1'b1;
        r_we = 1'b1;
      end
      swmh_pkg::OP_SCAN: begin
        c_re    = iss_on_q;
        c_raddr = iss_lab_q;
        // table lookup for the label whose count just came back
        t_re    = s1_v_q && (cnt_rd != '0);
        t_raddr = taddr(int'(hash_q), int'(s1_lab_q), int'(cnt_clip));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op_i == swmh_pkg::OP_CAPTURE) item_q <= in_data_i;
    if (c_re) vrd_q <= vld_q[c_raddr];
    s1_lab_q  <= iss_lab_q;
    s2_lab_q  <= s1_lab_q;
    s2_pres_q <= cnt_rd != '0;
    if (op_i == swmh_pkg::OP_EMIT && out_free) begin
      out_q.out_hash        <= swmh_pkg::HASH_W'(hash_q);
      out_q.min_value       <= best_q;
      out_q.min_label       <= swmh_pkg::LBL_W'(best_lab_q);
      out_q.window_empty    <= !found_q;
      out_q.count_saturated <= sat_q;
      out_q.last            <= hash_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      fill_q     <= '0;
      batch_q    <= '0;
      sat_q      <= 1'b0;
      hash_q     <= '0;
      vld_q      <= '0;
      iss_lab_q  <= '0;
      iss_on_q   <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      found_q    <= 1'b0;
      best_q     <= swmh_pkg::EMPTY_VALUE;
      best_lab_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      s1_v_q <= (op_i == swmh_pkg::OP_SCAN) && iss_on_q;
      s2_v_q <= (op_i == swmh_pkg::OP_SCAN) && s1_v_q;
      if (op_i == swmh_pkg::OP_EMIT && out_free) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
      unique case (op_i)
        swmh_pkg::OP_DROP_WR: fill_q <= fill_q - FW'(1);
        swmh_pkg::OP_PUSH_WR: begin
          vld_q[c_waddr] <= 1'b1;
          wp_q   <= (int'(wp_q) == WINDOW_MAX - 1) ? '0 : wp_q + WPW'(1);
          fill_q <= fill_q + FW'(1);
          if (int'(cnt_rd) + 1 > int'(ml)) sat_q <= 1'b1;
          if (status_o.report_due) batch_q <= '0;
          else batch_q <= batch_q + swmh_pkg::BATCH_W'(1);
        end
        swmh_pkg::OP_SCAN_INIT: begin
          iss_lab_q  <= '0;
          iss_on_q   <= 1'b1;
          found_q    <= 1'b0;
          best_q     <= swmh_pkg::EMPTY_VALUE;
          best_lab_q <= '0;
        end
        swmh_pkg::OP_SCAN: begin
          if (iss_on_q) begin
            if (int'(iss_lab_q) == int'(lc) - 1) iss_on_q <= 1'b0;
            else iss_lab_q <= iss_lab_q + CAW'(1);
          end
          // strict compare keeps the lowest label on ties
          if (s2_v_q && s2_pres_q && (!found_q || t_rdata < best_q)) begin
            found_q    <= 1'b1;
            best_q     <= t_rdata;
            best_lab_q <= s2_lab_q;
          end
        end
        swmh_pkg::OP_EMIT: begin
          if (out_free) begin
            if (hash_last) begin
              sat_q  <= 1'b0;
              hash_q <= '0;
            end else begin
              hash_q <= hash_q + HW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status_o.load_ok    = (item_q.command == swmh_pkg::CMD_LOAD) && (item_q.rank != '0) &&
                          (int'(item_q.rank) <= MULT_MAX) &&
                          (int'(item_q.hash_index) < HASH_COUNT) &&
                          (int'(item_q.table_label) < NUM_LABELS);
    status_o.push_ok    = (item_q.command == swmh_pkg::CMD_PUSH) &&
                          (int'(item_q.stream_label) < int'(lc));
    status_o.need_drop  = fill_q >= wl;
    status_o.report_due = (swmh_pkg::CFG_W'(batch_q) + 11'd1) >= bl;
    status_o.scan_done  = s2_v_q && (int'(s2_lab_q) == int'(lc) - 1);
    status_o.out_free   = out_free;
    status_o.hash_last  = hash_last;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
